FILE: rtl/core/lsc_pkg.sv
package lsc_pkg;

    // Four boundary lanes: left, right, bottom, top.
    localparam int LANES  = 4;
    localparam int LN_X0  = 0;  // q = x1 - left,   p = -dx
    localparam int LN_X1  = 1;  // q = right - x1,  p =  dx
    localparam int LN_Y0  = 2;  // q = y1 - bottom, p = -dy
    localparam int LN_Y1  = 3;  // q = top - y1,    p =  dy

    localparam logic [1:0] ST_VISIBLE  = 2'd0;
    localparam logic [1:0] ST_REJECT   = 2'd1;
    localparam logic [1:0] ST_PARALLEL = 2'd2;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 8'd3;

    localparam int WIN_LEFT_RST   = -300;
    localparam int WIN_RIGHT_RST  = 200;
    localparam int WIN_BOTTOM_RST = -200;
    localparam int WIN_TOP_RST    = 500;

    // Per-lane ratio flags: sign of q/p, |q| > |p|, |q| == |p|.
    typedef struct packed {
        logic neg;
        logic gt;
        logic eq;
    } t_rflag;

    localparam int RFLAG_W = $bits(t_rflag);

endpackage

FILE: rtl/core/lsc_prep.sv
module lsc_prep #(
    parameter int C = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [C-1:0]           i_x1,
    input  logic signed [C-1:0]           i_y1,
    input  logic signed [C-1:0]           i_x2,
    input  logic signed [C-1:0]           i_y2,
    input  logic signed [C-1:0]           i_left,
    input  logic signed [C-1:0]           i_right,
    input  logic signed [C-1:0]           i_bottom,
    input  logic signed [C-1:0]           i_top,
    output logic                          o_valid,
    output logic [C:0]                    o_aq [lsc_pkg::LANES],
    output logic [C:0]                    o_ap [lsc_pkg::LANES],
    output logic signed [C-1:0]           o_x1,
    output logic signed [C-1:0]           o_y1,
    output logic signed [C:0]             o_dx,
    output logic signed [C:0]             o_dy,
    output logic                          o_par,
    output lsc_pkg::t_rflag [lsc_pkg::LANES-1:0] o_flags
);
    import lsc_pkg::*;

    localparam int DW = C + 1;

    logic                 r_v1;
    logic signed [C-1:0]  r_x1, r_y1;
    logic signed [DW-1:0] r_dx, r_dy;
    logic signed [DW-1:0] r_q [LANES];

    logic                 r_v2;
    logic [DW-1:0]        n_aq [LANES];
    logic [DW-1:0]        n_ap [LANES];
    t_rflag [LANES-1:0]   n_flags;
    logic                 n_par;
    logic                 n_pneg [LANES];

    // Stage 1: differences.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_x1        <= i_x1;
            r_y1        <= i_y1;
            r_dx        <= DW'(i_x2) - DW'(i_x1);
            r_dy        <= DW'(i_y2) - DW'(i_y1);
            r_q[LN_X0]  <= DW'(i_x1) - DW'(i_left);
            r_q[LN_X1]  <= DW'(i_right) - DW'(i_x1);
            r_q[LN_Y0]  <= DW'(i_y1) - DW'(i_bottom);
            r_q[LN_Y1]  <= DW'(i_top) - DW'(i_y1);
        end
    end

    // Stage 2: magnitudes, signs, trivial-ratio flags, parallel-outside test.
    always_comb begin
        n_pneg[LN_X0] = !r_dx[DW-1] && (r_dx != '0);
        n_pneg[LN_X1] = r_dx[DW-1];
        n_pneg[LN_Y0] = !r_dy[DW-1] && (r_dy != '0);
        n_pneg[LN_Y1] = r_dy[DW-1];
        n_ap[LN_X0] = r_dx[DW-1] ? -r_dx : r_dx;
        n_ap[LN_X1] = n_ap[LN_X0];
        n_ap[LN_Y0] = r_dy[DW-1] ? -r_dy : r_dy;
        n_ap[LN_Y1] = n_ap[LN_Y0];
        for (int l = 0; l < LANES; l++) begin
            n_aq[l]        = r_q[l][DW-1] ? -r_q[l] : r_q[l];
            n_flags[l].neg = r_q[l][DW-1] ^ n_pneg[l];
            n_flags[l].gt  = n_aq[l] > n_ap[l];
            n_flags[l].eq  = n_aq[l] == n_ap[l];
        end
        n_par = ((r_dx == '0) && (r_q[LN_X0][DW-1] || r_q[LN_X1][DW-1]))
             || ((r_dy == '0) && (r_q[LN_Y0][DW-1] || r_q[LN_Y1][DW-1]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            o_aq    <= n_aq;
            o_ap    <= n_ap;
            o_flags <= n_flags;
            o_par   <= n_par;
            o_x1    <= r_x1;
            o_y1    <= r_y1;
            o_dx    <= r_dx;
            o_dy    <= r_dy;
        end
    end

    assign o_valid = r_v2;

endmodule

FILE: rtl/core/lsc_div.sv
module lsc_div #(
    parameter int MW = 17,
    parameter int F  = 16,
    parameter int SW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [MW-1:0] i_aq [lsc_pkg::LANES],
    input  logic [MW-1:0] i_ap [lsc_pkg::LANES],
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [F-1:0]  o_quo [lsc_pkg::LANES],
    output logic [SW-1:0] o_side
);
    import lsc_pkg::*;

    // Remainder stays below 2*|p| while |q| < |p|.
    localparam int RW = MW + 1;

    logic          r_v    [F+1];
    logic [RW-1:0] r_rem  [F+1][LANES];
    logic [MW-1:0] r_ap   [F+1][LANES];
    logic [F-1:0]  r_quo  [F+1][LANES];
    logic [SW-1:0] r_side [F+1];

    always_comb begin
        r_v[0]    = i_valid;
        r_side[0] = i_side;
        for (int l = 0; l < LANES; l++) begin
            r_rem[0][l] = RW'(i_aq[l]);
            r_ap[0][l]  = i_ap[l];
            r_quo[0][l] = '0;
        end
    end

    // One restoring quotient bit per stage.
    for (genvar k = 0; k < F; k++) begin : g_step
        logic [RW-1:0] n_sh  [LANES];
        logic          n_bit [LANES];

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                n_sh[l]  = {r_rem[k][l][RW-2:0], 1'b0};
                n_bit[l] = n_sh[l] >= RW'(r_ap[k][l]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_side[k+1] <= r_side[k];
                for (int l = 0; l < LANES; l++) begin
                    r_rem[k+1][l] <= n_bit[l] ? n_sh[l] - RW'(r_ap[k][l]) : n_sh[l];
                    r_ap[k+1][l]  <= r_ap[k][l];
                    r_quo[k+1][l] <= {r_quo[k][l][F-2:0], n_bit[l]};
                end
            end
        end
    end

    assign o_valid = r_v[F];
    assign o_side  = r_side[F];
    assign o_quo   = r_quo[F];

endmodule

FILE: rtl/core/lsc_interp.sv
module lsc_interp #(
    parameter int C = 16,
    parameter int F = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [F-1:0]                  i_quo [lsc_pkg::LANES],
    input  lsc_pkg::t_rflag [lsc_pkg::LANES-1:0] i_flags,
    input  logic                          i_par,
    input  logic signed [C-1:0]           i_x1,
    input  logic signed [C-1:0]           i_y1,
    input  logic signed [C:0]             i_dx,
    input  logic signed [C:0]             i_dy,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic [C-1:0]                  o_sx,
    output logic [C-1:0]                  o_sy,
    output logic [C-1:0]                  o_ex,
    output logic [C-1:0]                  o_ey
);
    import lsc_pkg::*;

    localparam int DW  = C + 1;
    localparam int RSW = F + 3;
    localparam int PW  = DW + F + 1;
    localparam int MQW = PW - F;
    localparam int SSW = DW + 3;
    localparam logic signed [RSW-1:0] ONE_R = RSW'(1) <<< F;

    // Stage T1: signed ratios, sorted into entry and exit per axis.
    logic signed [RSW-1:0] n_r [LANES];
    logic signed [RSW-1:0] n_mag [LANES];
    logic                  n_dxz, n_dxp, n_dyz, n_dyp;

    logic                  r_v1, r_par1;
    logic signed [RSW-1:0] r_entx, r_enty, r_extx, r_exty;
    logic signed [C-1:0]   r_x1a, r_y1a;
    logic signed [DW-1:0]  r_dxa, r_dya;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (i_flags[l].gt) begin
                n_mag[l] = ONE_R + RSW'(1);
            end else if (i_flags[l].eq) begin
                n_mag[l] = ONE_R;
            end else begin
                n_mag[l] = RSW'(i_quo[l]);
            end
            n_r[l] = (i_flags[l].neg && n_mag[l] != '0) ? -n_mag[l] : n_mag[l];
        end
        n_dxz = i_dx == '0;
        n_dxp = !i_dx[DW-1] && !n_dxz;
        n_dyz = i_dy == '0;
        n_dyp = !i_dy[DW-1] && !n_dyz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_entx <= n_dxz ? '0 : (n_dxp ? n_r[LN_X0] : n_r[LN_X1]);
            r_extx <= n_dxz ? ONE_R : (n_dxp ? n_r[LN_X1] : n_r[LN_X0]);
            r_enty <= n_dyz ? '0 : (n_dyp ? n_r[LN_Y0] : n_r[LN_Y1]);
            r_exty <= n_dyz ? ONE_R : (n_dyp ? n_r[LN_Y1] : n_r[LN_Y0]);
            r_par1 <= i_par;
            r_x1a  <= i_x1;
            r_y1a  <= i_y1;
            r_dxa  <= i_dx;
            r_dya  <= i_dy;
        end
    end

    // Stage T2: u1 = max(0, entries), u2 = min(1, exits), decide status.
    logic signed [RSW-1:0] n_emax, n_xmin, n_u1, n_u2;
    logic [1:0]            n_st;

    logic                  r_v2;
    logic [1:0]            r_st2;
    logic [F:0]            r_u1, r_u2;
    logic signed [C-1:0]   r_x1b, r_y1b;
    logic signed [DW-1:0]  r_dxb, r_dyb;

    always_comb begin
        n_emax = (r_entx > r_enty) ? r_entx : r_enty;
        n_u1   = (!n_emax[RSW-1]) ? n_emax : '0;
        n_xmin = (r_extx < r_exty) ? r_extx : r_exty;
        n_u2   = (n_xmin < ONE_R) ? n_xmin : ONE_R;
        if (r_par1) begin
            n_st = ST_PARALLEL;
        end else if (n_u1 > n_u2) begin
            n_st = ST_REJECT;
        end else begin
            n_st = ST_VISIBLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_st2 <= n_st;
            r_u1  <= n_u1[F:0];
            r_u2  <= n_u2[F:0];
            r_x1b <= r_x1a;
            r_y1b <= r_y1a;
            r_dxb <= r_dxa;
            r_dyb <= r_dya;
        end
    end

    // Stage T3: |d| * u products.
    logic [DW-1:0]        n_adx, n_ady;
    logic                 r_v3;
    logic [1:0]           r_st3;
    logic [PW-1:0]        r_psx, r_psy, r_pex, r_pey;
    logic signed [C-1:0]  r_x1c, r_y1c;
    logic                 r_dxn, r_dyn;

    assign n_adx = r_dxb[DW-1] ? -r_dxb : r_dxb;
    assign n_ady = r_dyb[DW-1] ? -r_dyb : r_dyb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
        if (i_en) begin
            r_st3 <= r_st2;
            r_psx <= PW'(n_adx) * PW'(r_u1);
            r_psy <= PW'(n_ady) * PW'(r_u1);
            r_pex <= PW'(n_adx) * PW'(r_u2);
            r_pey <= PW'(n_ady) * PW'(r_u2);
            r_x1c <= r_x1b;
            r_y1c <= r_y1b;
            r_dxn <= r_dxb[DW-1];
            r_dyn <= r_dyb[DW-1];
        end
    end

    // Stage T4: base + d*u, truncated toward zero; zero for non-visible results.
    function automatic logic [C-1:0] f_point(
        input logic signed [C-1:0] base,
        input logic                dneg,
        input logic [PW-1:0]       prod,
        input logic [1:0]          st
    );
        logic [MQW-1:0]        m;
        logic                  frac;
        logic signed [SSW-1:0] fl;
        logic signed [SSW-1:0] s;
        m    = prod[PW-1:F];
        frac = prod[F-1:0] != '0;
        fl   = dneg ? -SSW'(m) - SSW'(frac) : SSW'(m);
        s    = SSW'(base) + fl;
        if (s[SSW-1] && frac) begin
            s = s + SSW'(1);
        end
        return (st == ST_VISIBLE) ? s[C-1:0] : '0;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v3;
        end
        if (i_en) begin
            o_status <= r_st3;
            o_sx     <= f_point(r_x1c, r_dxn, r_psx, r_st3);
            o_sy     <= f_point(r_y1c, r_dyn, r_psy, r_st3);
            o_ex     <= f_point(r_x1c, r_dxn, r_pex, r_st3);
            o_ey     <= f_point(r_y1c, r_dyn, r_pey, r_st3);
        end
    end

endmodule

FILE: rtl/core/line_segment_clipper.sv
// Channel | Direction | Transaction carries
// s_axis  | in        | tdata: start_x, start_y, end_x, end_y (COORD_BITS each, low first)
// m_axis  | out       | tdata: clipped start x/y, end x/y; tuser: clip_status
// cfg     | in        | i_cfg_index selects left/right/bottom/top, i_cfg_data the value
//
// One segment per cycle while m_axis is not stalled; the pipeline is the divider
// pipeline (one quotient bit per stage) plus two prep and four clip/interp stages.
// Reset (i_rst_n low, synchronous) empties the pipeline and loads the default window.
// A stall on m_axis freezes every stage at once; s_axis_tready follows it.
module line_segment_clipper #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input segments
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // start_x, start_y, end_x, end_y, zero pad
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // clipped segments
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y, zero pad
    output logic [((4*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    // clip_status
    output logic [1:0]                       m_axis_tuser,
    // window configuration
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lsc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [COORD_BITS-1:0]            i_cfg_data
);
    import lsc_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int DW   = C + 1;
    localparam int TW   = ((4*C+7)/8)*8;
    localparam int FLW  = LANES * RFLAG_W;
    localparam int SW   = 2*C + 2*DW + 1 + FLW;
    // side-band layout, lowest bit first
    localparam int O_Y1 = C;
    localparam int O_DX = 2*C;
    localparam int O_DY = 2*C + DW;
    localparam int O_PR = 2*C + 2*DW;
    localparam int O_FL = O_PR + 1;

    // Window registers; writes to unknown indexes are dropped.
    logic signed [C-1:0] r_left, r_right, r_bottom, r_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= C'(WIN_LEFT_RST);
            r_right  <= C'(WIN_RIGHT_RST);
            r_bottom <= C'(WIN_BOTTOM_RST);
            r_top    <= C'(WIN_TOP_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_LEFT:   r_left   <= i_cfg_data;
                REG_RIGHT:  r_right  <= i_cfg_data;
                REG_BOTTOM: r_bottom <= i_cfg_data;
                REG_TOP:    r_top    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Global advance: the whole pipe moves when the output slot is free or draining.
    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    logic                 p_valid;
    logic [DW-1:0]        p_aq [LANES];
    logic [DW-1:0]        p_ap [LANES];
    logic signed [C-1:0]  p_x1, p_y1;
    logic signed [DW-1:0] p_dx, p_dy;
    logic                 p_par;
    t_rflag [LANES-1:0]   p_flags;
    logic [SW-1:0]        p_side;

    lsc_prep #(.C(C)) u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (s_axis_tvalid),
        .i_x1     (s_axis_tdata[C-1:0]),
        .i_y1     (s_axis_tdata[2*C-1:C]),
        .i_x2     (s_axis_tdata[3*C-1:2*C]),
        .i_y2     (s_axis_tdata[4*C-1:3*C]),
        .i_left   (r_left),
        .i_right  (r_right),
        .i_bottom (r_bottom),
        .i_top    (r_top),
        .o_valid  (p_valid),
        .o_aq     (p_aq),
        .o_ap     (p_ap),
        .o_x1     (p_x1),
        .o_y1     (p_y1),
        .o_dx     (p_dx),
        .o_dy     (p_dy),
        .o_par    (p_par),
        .o_flags  (p_flags)
    );

    assign p_side = {p_flags, p_par, p_dy, p_dx, p_y1, p_x1};

    logic          d_valid;
    logic [F-1:0]  d_quo [LANES];
    logic [SW-1:0] d_side;

    lsc_div #(.MW(DW), .F(F), .SW(SW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (p_valid),
        .i_aq    (p_aq),
        .i_ap    (p_ap),
        .i_side  (p_side),
        .o_valid (d_valid),
        .o_quo   (d_quo),
        .o_side  (d_side)
    );

    logic [1:0]   o_status;
    logic [C-1:0] o_sx, o_sy, o_ex, o_ey;

    lsc_interp #(.C(C), .F(F)) u_interp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (d_valid),
        .i_quo    (d_quo),
        .i_flags  (d_side[O_FL +: FLW]),
        .i_par    (d_side[O_PR]),
        .i_x1     (d_side[C-1:0]),
        .i_y1     (d_side[O_Y1 +: C]),
        .i_dx     (d_side[O_DX +: DW]),
        .i_dy     (d_side[O_DY +: DW]),
        .o_valid  (m_axis_tvalid),
        .o_status (o_status),
        .o_sx     (o_sx),
        .o_sy     (o_sy),
        .o_ex     (o_ex),
        .o_ey     (o_ey)
    );

    assign m_axis_tuser = o_status;
    assign m_axis_tdata = TW'({o_ey, o_ex, o_sy, o_sx});

`ifndef ASSERT_OFF
    // Non-visible results carry zero endpoints.
    a_zero_coords: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_VISIBLE |-> m_axis_tdata == '0)
        else $error("non-visible result with nonzero endpoints");

    // Status is one of the three defined codes.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser == ST_VISIBLE || m_axis_tuser == ST_REJECT
                          || m_axis_tuser == ST_PARALLEL)
        else $error("undefined clip status");

    // Pipeline comes out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

FILE: tb/tb_line_segment_clipper.sv
module tb_line_segment_clipper;
    timeunit 1ns;
    timeprecision 1ps;

    import lsc_pkg::*;

    localparam int CB      = 16;
    localparam int FB      = 16;
    localparam int DW      = ((4*CB+7)/8)*8;
    localparam int LAT     = FB + 6;
    localparam int WDOG    = 20000;
    localparam int N_RAND  = 1300;

    // One clipped segment as it leaves the block.
    typedef struct packed {
        logic [1:0]    status;
        logic [CB-1:0] sx;
        logic [CB-1:0] sy;
        logic [CB-1:0] ex;
        logic [CB-1:0] ey;
    } clip_t;

    // One row of the directed table; chk marks a hand-typed expectation.
    typedef struct {
        logic [CB-1:0] x1, y1, x2, y2;
        bit            chk;
        clip_t         res;
    } seg_row_t;

    logic i_clk, i_rst_n;
    logic s_axis_tvalid, s_axis_tready;
    logic [DW-1:0] s_axis_tdata;
    logic m_axis_tvalid, m_axis_tready;
    logic [DW-1:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CB-1:0] i_cfg_data;

    line_segment_clipper #(.COORD_BITS(CB), .FRAC_BITS(FB)) uut (.*);

    // Predictor's copy of the window.
    longint w_left, w_right, w_bottom, w_top;

    clip_t clip_q[$];
    int    errors;
    int    idle_cnt;
    int    n_seg, n_vis, n_rej, n_par;
    bit    src_burst_ok;   // sender may idle
    bit    snk_burst_ok;   // receiver may stall
    bit    hold_sink;      // long receiver hold-off requested

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Fixed-point |q|/|p| with sign, clamped past one.
    function automatic longint fx_ratio(longint q, longint p);
        longint aq, ap, rem, quo, r;
        aq = (q < 0) ? -q : q;
        ap = (p < 0) ? -p : p;
        quo = 0;
        if (aq > ap) r = (64'sd1 << FB) + 1;
        else if (aq == ap) r = 64'sd1 << FB;
        else begin
            rem = aq;
            for (int i = 0; i < FB; i++) begin
                rem = rem << 1;
                quo = quo << 1;
                if (rem >= ap) begin
                    rem -= ap;
                    quo |= 1;
                end
            end
            r = quo;
        end
        return (((q < 0) != (p < 0)) && r != 0) ? -r : r;
    endfunction

    // base + prod/2^FB, truncated toward zero as a whole.
    function automatic logic [CB-1:0] fx_exact(longint base, longint prod);
        longint num, s;
        num = (base <<< FB) + prod;
        s = num / (64'sd1 << FB);
        return s[CB-1:0];
    endfunction

    // base + d*t/2^FB truncated toward zero; d*t fits easily in 64 bits here.
    function automatic logic [CB-1:0] fx_point(longint base, longint d, longint t);
        return fx_exact(base, d * t);
    endfunction

    function automatic clip_t clip_segment(logic [CB-1:0] ax, ay, bx, by);
        clip_t  r;
        longint x1, y1, dx, dy, u1, u2, ra, rb;
        x1 = longint'($signed(ax));
        y1 = longint'($signed(ay));
        dx = longint'($signed(bx)) - x1;
        dy = longint'($signed(by)) - y1;
        r = '0;
        u1 = 0;
        u2 = 64'sd1 << FB;
        if ((dx == 0 && (x1 < w_left || x1 > w_right)) ||
            (dy == 0 && (y1 < w_bottom || y1 > w_top))) begin
            r.status = ST_PARALLEL;
            return r;
        end
        if (dx != 0) begin
            ra = fx_ratio(x1 - w_left, -dx);
            rb = fx_ratio(w_right - x1, dx);
            if (dx > 0) begin
                if (ra > u1) u1 = ra;
                if (rb < u2) u2 = rb;
            end else begin
                if (rb > u1) u1 = rb;
                if (ra < u2) u2 = ra;
            end
        end
        if (dy != 0) begin
            ra = fx_ratio(y1 - w_bottom, -dy);
            rb = fx_ratio(w_top - y1, dy);
            if (dy > 0) begin
                if (ra > u1) u1 = ra;
                if (rb < u2) u2 = rb;
            end else begin
                if (rb > u1) u1 = rb;
                if (ra < u2) u2 = ra;
            end
        end
        if (u1 > u2) begin
            r.status = ST_REJECT;
            return r;
        end
        r.status = ST_VISIBLE;
        r.sx = fx_point(x1, dx, u1);
        r.sy = fx_point(y1, dy, u1);
        r.ex = fx_point(x1, dx, u2);
        r.ey = fx_point(y1, dy, u2);
        return r;
    endfunction

    // Offer one segment and hold it until the transaction completes.
    task automatic send_segment(logic [CB-1:0] ax, ay, bx, by, bit chk, clip_t res);
        int gap;
        if (src_burst_ok && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {by, bx, ay, ax};
        clip_q.push_back(chk ? res : clip_segment(ax, ay, bx, by));
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_seg++;
    endtask

    task automatic idle_off();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait out the pipeline, then write one register.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CB-1:0] val);
        while (clip_q.size() != 0) @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_LEFT:   w_left   = longint'($signed(val));
            REG_RIGHT:  w_right  = longint'($signed(val));
            REG_BOTTOM: w_bottom = longint'($signed(val));
            REG_TOP:    w_top    = longint'($signed(val));
            default: ;
        endcase
    endtask

    task automatic set_window(int l, int r, int b, int t);
        write_reg(REG_LEFT, CB'(l));
        write_reg(REG_RIGHT, CB'(r));
        write_reg(REG_BOTTOM, CB'(b));
        write_reg(REG_TOP, CB'(t));
    endtask

    // Random coordinate: mostly near the window, sometimes full range.
    function automatic logic [CB-1:0] rnd_coord(longint lo, longint hi);
        longint v;
        case ($urandom_range(0, 3))
            0: v = $signed(16'($urandom));
            1: v = (lo < hi ? lo : hi) + $urandom_range(0, 60) - 30;
            default: v = lo + ($urandom % (((hi > lo) ? hi - lo : lo - hi) + 200)) - 100;
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[CB-1:0];
    endfunction

    task automatic random_segments(int n);
        logic [CB-1:0] ax, ay, bx, by;
        clip_t nul;
        nul = '0;
        repeat (n) begin
            ax = rnd_coord(w_left, w_right);
            ay = rnd_coord(w_bottom, w_top);
            bx = rnd_coord(w_left, w_right);
            by = rnd_coord(w_bottom, w_top);
            case ($urandom_range(0, 9))
                0: bx = ax;                  // vertical
                1: by = ay;                  // horizontal
                2: begin bx = ax; by = ay; end
                default: ;
            endcase
            send_segment(ax, ay, bx, by, 1'b0, nul);
        end
    endtask

    // Receiver: random stalls, or one long hold-off on request.
    initial begin
        int n;
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_sink) begin
                m_axis_tready <= 1'b0;
                n = 0;
                while (n < 3 * LAT) begin
                    @(posedge i_clk);
                    n++;
                end
                hold_sink = 1'b0;
            end else if (snk_burst_ok && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Compare every accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        clip_t want, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tuser;
            {got.ey, got.ex, got.sy, got.sx} = m_axis_tdata[4*CB-1:0];
            if (clip_q.size() == 0) begin
                $error("unexpected result status=%0d", got.status);
                errors++;
            end else begin
                want = clip_q.pop_front();
                if (want.status == ST_VISIBLE) n_vis++;
                else if (want.status == ST_REJECT) n_rej++;
                else n_par++;
                if (got.status !== want.status) begin
                    $error("clip_status exp %0d got %0d", want.status, got.status);
                    errors++;
                end
                if (got.sx !== want.sx) begin
                    $error("clipped_start_x exp %0d got %0d", $signed(want.sx), $signed(got.sx));
                    errors++;
                end
                if (got.sy !== want.sy) begin
                    $error("clipped_start_y exp %0d got %0d", $signed(want.sy), $signed(got.sy));
                    errors++;
                end
                if (got.ex !== want.ex) begin
                    $error("clipped_end_x exp %0d got %0d", $signed(want.ex), $signed(got.ex));
                    errors++;
                end
                if (got.ey !== want.ey) begin
                    $error("clipped_end_y exp %0d got %0d", $signed(want.ey), $signed(got.ey));
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no transaction on any channel.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WDOG) begin
            $display("watchdog expired with %0d results pending", clip_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        seg_row_t rows[$];
        seg_row_t rw;
        clip_t z;
        int drain;
        errors = 0; idle_cnt = 0;
        n_seg = 0; n_vis = 0; n_rej = 0; n_par = 0;
        src_burst_ok = 1'b0; snk_burst_ok = 1'b0; hold_sink = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        w_left = WIN_LEFT_RST; w_right = WIN_RIGHT_RST;
        w_bottom = WIN_BOTTOM_RST; w_top = WIN_TOP_RST;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table against the reset window.
        z = '0;
        // fully inside: passes unchanged
        rw = '{16'sd0, 16'sd0, 16'sd100, 16'sd100, 1'b1,
               '{ST_VISIBLE, 16'sd0, 16'sd0, 16'sd100, 16'sd100}};
        rows.push_back(rw);
        // single point inside
        rw = '{16'sd5, 16'sd7, 16'sd5, 16'sd7, 1'b1, '{ST_VISIBLE, 16'sd5, 16'sd7, 16'sd5, 16'sd7}};
        rows.push_back(rw);
        // single point outside
        z.status = ST_PARALLEL;
        rw = '{16'sd900, 16'sd7, 16'sd900, 16'sd7, 1'b1, z};
        rows.push_back(rw);
        // vertical outside, horizontal outside
        rw = '{-16'sd400, 16'sd0, -16'sd400, 16'sd50, 1'b1, z}; rows.push_back(rw);
        rw = '{16'sd0, 16'sd600, 16'sd90, 16'sd600, 1'b1, z};   rows.push_back(rw);
        // missing the corner entirely
        z.status = ST_REJECT;
        rw = '{16'sd150, 16'sd700, 16'sd400, 16'sd300, 1'b1, z}; rows.push_back(rw);
        // extremes of the fields and crossing segments, via predictor
        z = '0;
        rw = '{16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 1'b0, z}; rows.push_back(rw);
        rw = '{16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 1'b0, z}; rows.push_back(rw);
        rw = '{16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 1'b0, z}; rows.push_back(rw);
        rw = '{16'hffff, 16'h0000, 16'h7fff, 16'h0001, 1'b0, z}; rows.push_back(rw);
        rw = '{-16'sd500, 16'sd100, 16'sd500, 16'sd100, 1'b0, z}; rows.push_back(rw);
        rw = '{16'sd0, -16'sd900, 16'sd0, 16'sd900, 1'b0, z};     rows.push_back(rw);
        rw = '{-16'sd300, -16'sd200, 16'sd200, 16'sd500, 1'b0, z}; rows.push_back(rw);
        rw = '{16'sd333, -16'sd777, -16'sd555, 16'sd999, 1'b0, z}; rows.push_back(rw);
        rw = '{16'sd199, 16'sd499, 16'sd201, 16'sd501, 1'b0, z};   rows.push_back(rw);
        foreach (rows[i]) send_segment(rows[i].x1, rows[i].y1, rows[i].x2, rows[i].y2,
                                       rows[i].chk, rows[i].res);
        idle_off();

        // Inverted window and the extreme window, then an ignored index.
        set_window(100, -100, 50, -50);
        random_segments(40);
        idle_off();
        set_window(-32768, 32767, -32768, 32767);
        write_reg(CFG_IDX_W'(7), 16'h1234);
        random_segments(60);
        idle_off();

        // Long receiver hold-off while segments keep coming; block must back up.
        set_window(-1000, 1000, -700, 800);
        hold_sink = 1'b1;
        random_segments(3 * LAT);
        idle_off();
        // Sender pauses until every expectation has cleared.
        while (clip_q.size() != 0) @(posedge i_clk);

        // Random part with idling on both sides, across several windows.
        src_burst_ok = 1'b1; snk_burst_ok = 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_window(-300, 200, -200, 500);
                1: set_window(-32768, 32767, -32768, 32767);
                2: set_window(32767, -32768, 32767, -32768);
                3: set_window(0, 0, 0, 0);
                default: set_window($signed(16'($urandom)), $signed(16'($urandom)),
                                    $signed(16'($urandom)), $signed(16'($urandom)));
            endcase
            random_segments(N_RAND / 8);
            idle_off();
        end
        // Final stretch without idling.
        src_burst_ok = 1'b0; snk_burst_ok = 1'b0;
        set_window(-2000, 1500, -1200, 1800);
        random_segments(N_RAND / 4);
        idle_off();

        drain = 0;
        while (clip_q.size() != 0 && drain < WDOG) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (LAT + 4) @(posedge i_clk);
        if (clip_q.size() != 0) begin
            $error("%0d expected results never arrived", clip_q.size());
            errors++;
        end
        $display("Clipped %0d segments: %0d visible, %0d rejected, %0d parallel-outside,",
                 n_seg, n_vis, n_rej, n_par);
        $display("over reset, inverted, full-range, degenerate and random windows.");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
